>>> src/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// Shared widths, codes and helpers for the byte ring FIFO with fill levels.
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int LOG2_DEPTH = 10;
    localparam int DEPTH      = 1 << LOG2_DEPTH;
    localparam int AW         = LOG2_DEPTH;        // store address
    localparam int CW         = LOG2_DEPTH + 1;    // free-running counters, levels
    localparam int LW         = 4;                 // size register
    localparam int DW         = 8;                 // byte
    localparam int OPW        = 3;
    localparam int FCW        = 3;

    typedef enum logic [OPW-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_SKIP   = 3'd3,
        OP_CLAIM  = 3'd4,
        OP_MOVEIN = 3'd5,
        OP_RESET  = 3'd6
    } t_op;

    typedef enum logic [FCW-1:0] {
        FILL_EMPTY        = 3'd0,
        FILL_FULL         = 3'd1,
        FILL_ALMOST_FULL  = 3'd2,
        FILL_HALF         = 3'd3,
        FILL_ALMOST_EMPTY = 3'd4,
        FILL_PARTIAL      = 3'd5
    } t_fill;

    // counter update and store access for one word
    typedef struct packed {
        logic [CW-1:0] wc;
        logic [CW-1:0] rc;
        logic          we;
        logic          re;
        logic [AW-1:0] addr;
        logic [CW-1:0] done;
    } t_step;

    function automatic t_fill fill_class(input logic [CW-1:0] lev,
                                         input logic [CW-1:0] size);
        logic [CW-1:0] q1;
        logic [CW-1:0] h;
        logic [CW-1:0] e1;
        t_fill         fc;
        q1 = size >> 2;
        h  = size >> 1;
        e1 = size >> 3;
        if (lev == '0) begin
            fc = FILL_EMPTY;
        end else if (lev == size) begin
            fc = FILL_FULL;
        end else if (lev >= size - q1) begin
            fc = FILL_ALMOST_FULL;
        end else if (lev >= h - e1 && lev <= h + e1) begin
            fc = FILL_HALF;
        end else if (lev <= q1) begin
            fc = FILL_ALMOST_EMPTY;
        end else begin
            fc = FILL_PARTIAL;
        end
        return fc;
    endfunction

endpackage

>>> src/brf_ram.sv
// ----------------------------------------------------------------------------
// brf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/brf_step.sv
// ----------------------------------------------------------------------------
// brf_step
// Per-word operation decode: next read/write counters, store access, count.
// ----------------------------------------------------------------------------
module brf_step (
    input  logic [brf_pkg::OPW-1:0] i_op,
    input  logic [brf_pkg::CW-1:0]  i_count,
    input  logic [brf_pkg::AW-1:0]  i_offset,
    input  logic [brf_pkg::AW-1:0]  i_dma_index,
    input  logic [brf_pkg::CW-1:0]  i_wc,
    input  logic [brf_pkg::CW-1:0]  i_rc,
    input  logic [brf_pkg::CW-1:0]  i_size,
    input  logic [brf_pkg::AW-1:0]  i_smask,
    output brf_pkg::t_step          o_step
);
    import brf_pkg::*;

    logic [CW-1:0] lev;
    logic [CW-1:0] room;
    logic [AW-1:0] mv_dist;
    logic [CW-1:0] mv_wc;
    logic [CW-1:0] mv_lev;

    assign lev     = i_wc - i_rc;
    assign room    = i_size - lev;
    assign mv_dist = ((i_dma_index & i_smask) - (i_wc[AW-1:0] & i_smask)) & i_smask;
    assign mv_wc   = i_wc + {1'b0, mv_dist};
    assign mv_lev  = mv_wc - i_rc;

    always_comb begin
        o_step      = '0;
        o_step.wc   = i_wc;
        o_step.rc   = i_rc;
        o_step.addr = i_rc[AW-1:0] & i_smask;
        unique case (t_op'(i_op))
            OP_PUSH: begin
                o_step.addr = i_wc[AW-1:0] & i_smask;
                if (lev < i_size) begin
                    o_step.we   = 1'b1;
                    o_step.wc   = i_wc + CW'(1);
                    o_step.done = CW'(1);
                end
            end
            OP_POP: begin
                if (lev != '0) begin
                    o_step.re   = 1'b1;
                    o_step.rc   = i_rc + CW'(1);
                    o_step.done = CW'(1);
                end
            end
            OP_PEEK: begin
                o_step.addr = (i_rc[AW-1:0] + i_offset) & i_smask;
                if ({1'b0, i_offset} < lev) begin
                    o_step.re   = 1'b1;
                    o_step.done = CW'(1);
                end
            end
            OP_SKIP: begin
                o_step.done = (i_count < lev) ? i_count : lev;
                o_step.rc   = i_rc + o_step.done;
            end
            OP_CLAIM: begin
                o_step.done = (i_count < room) ? i_count : room;
                o_step.wc   = i_wc + o_step.done;
            end
            OP_MOVEIN: begin
                o_step.done = {1'b0, mv_dist};
                o_step.wc   = mv_wc;
                // overrun drops the oldest bytes
                if (mv_lev > i_size) begin
                    o_step.rc = mv_wc - i_size;
                end
            end
            OP_RESET: begin
                o_step.wc = '0;
                o_step.rc = '0;
            end
            default: begin
            end
        endcase
    end

endmodule

>>> src/byte_ring_fifo_with_levels.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_levels
// Power-of-two byte ring with free-running counters, levels and fill class.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------
//  input    | in        | i_valid / o_stall     | op, data_in, count, offset,
//           |           |                       | dma_index
//  result   | out       | o_valid / i_stall     | data_out, done_count, level,
//           |           |                       | free_space, fill_class
//  config   | in        | i_cfg_valid / o_cfg_ready | log2_size
//
//  One word accepted per clock while o_stall is low; its result passes stage
//  1 (store read), then the output register. Counters and store writes update
//  at the accepting edge, so back-to-back words see each other's effects. After
//  reset a pass over all 1024 addresses zeroes the store with o_stall high.
//  A stalled result holds the output register; one word can wait behind it.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_levels (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input words
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [brf_pkg::OPW-1:0]  i_op,
    input  logic [brf_pkg::DW-1:0]   i_data_in,
    input  logic [brf_pkg::CW-1:0]   i_count,
    input  logic [brf_pkg::AW-1:0]   i_offset,
    input  logic [brf_pkg::AW-1:0]   i_dma_index,
    // results
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [brf_pkg::DW-1:0]   o_data_out,
    output logic [brf_pkg::CW-1:0]   o_done_count,
    output logic [brf_pkg::CW-1:0]   o_level,
    output logic [brf_pkg::CW-1:0]   o_free_space,
    output logic [brf_pkg::FCW-1:0]  o_fill_class,
    // configuration
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [brf_pkg::LW-1:0]   i_log2_size
);
    import brf_pkg::*;

    // ring state
    logic [CW-1:0] r_wc, n_wc;
    logic [CW-1:0] r_rc, n_rc;
    logic [LW-1:0] r_log2_size;

    // store clearing pass
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // stage 1: store read in flight
    logic          r_s1_valid;
    logic          r_s1_rd;
    logic [CW-1:0] r_s1_done;
    logic [CW-1:0] r_s1_level;
    logic [CW-1:0] r_s1_size;

    // output register
    logic           r_out_valid;
    logic [DW-1:0]  r_out_data;
    logic [CW-1:0]  r_out_done;
    logic [CW-1:0]  r_out_level;
    logic [CW-1:0]  r_out_free;
    logic [FCW-1:0] r_out_fill;

    logic [LW-1:0] log2_eff;
    logic [CW-1:0] size;
    logic [AW-1:0] smask;
    t_step         step;
    logic          s1_adv;
    logic          accept;
    logic          cfg_wr;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [DW-1:0] ram_rdata;

    assign log2_eff = (r_log2_size > LW'(LOG2_DEPTH)) ? LW'(LOG2_DEPTH) : r_log2_size;
    assign size     = CW'(1) << log2_eff;
    assign smask    = AW'(size - CW'(1));

    brf_step u_step (
        .i_op        (i_op),
        .i_count     (i_count),
        .i_offset    (i_offset),
        .i_dma_index (i_dma_index),
        .i_wc        (r_wc),
        .i_rc        (r_rc),
        .i_size      (size),
        .i_smask     (smask),
        .o_step      (step)
    );

    assign s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_clr_busy || (r_s1_valid && !s1_adv);
    assign accept  = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr  = i_cfg_valid && o_cfg_ready;

    assign ram_we    = r_clr_busy || (accept && step.we);
    assign ram_waddr = r_clr_busy ? r_clr_addr : step.addr;
    assign ram_wdata = r_clr_busy ? '0 : i_data_in;

    brf_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept && step.re),
        .i_raddr (step.addr),
        .o_rdata (ram_rdata)
    );

    // a size write starts a new, empty ring
    always_comb begin
        n_wc = r_wc;
        n_rc = r_rc;
        if (cfg_wr) begin
            n_wc = '0;
            n_rc = '0;
        end else if (accept) begin
            n_wc = step.wc;
            n_rc = step.rc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc        <= '0;
            r_rc        <= '0;
            r_log2_size <= LW'(LOG2_DEPTH);
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wc <= n_wc;
            r_rc <= n_rc;
            if (cfg_wr) begin
                r_log2_size <= i_log2_size;
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_rd    <= step.re;
            r_s1_done  <= step.done;
            r_s1_level <= step.wc - step.rc;
            r_s1_size  <= size;
        end
        if (s1_adv) begin
            r_out_data  <= r_s1_rd ? ram_rdata : '0;
            r_out_done  <= r_s1_done;
            r_out_level <= r_s1_level;
            r_out_free  <= r_s1_size - r_s1_level;
            r_out_fill  <= FCW'(fill_class(r_s1_level, r_s1_size));
        end
    end

    assign o_valid      = r_out_valid;
    assign o_data_out   = r_out_data;
    assign o_done_count = r_out_done;
    assign o_level      = r_out_level;
    assign o_free_space = r_out_free;
    assign o_fill_class = r_out_fill;

endmodule
